@@ hw/rtl/hm74_pkg.sv @@
// ----------------------------------------------------------------------------
// hm74_pkg
// Shared types and Hamming(7,4) helper functions for the packed codec.
// ----------------------------------------------------------------------------
package hm74_pkg;

  localparam int BufW   = 21;  // pending bit store
  localparam int CntW   = 5;   // pending bit count
  localparam int MaxRes = 3;   // max result beats per input beat

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // stream state carried between beats
  typedef struct packed {
    logic [BufW-1:0] bits;
    logic [CntW-1:0] cnt;
    logic [3:0]      held_nib;
    logic            held;
    logic            err;
  } hm74_state_t;

  // one result beat
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       corr;
  } hm74_res_t;

  // all results of one input beat, entry 0 goes out first
  typedef struct packed {
    hm74_res_t [MaxRes-1:0] ent;
    logic [1:0]             n;
  } hm74_batch_t;

  typedef struct packed {
    logic       fixed;
    logic [3:0] nib;
  } hm74_dec_t;

  // nibble d3..d0 -> p1 p2 p3 d3 d2 d1 d0
  function automatic logic [6:0] enc_nibble(input logic [3:0] d);
    logic p1, p2, p3;
    p1 = d[2] ^ d[1] ^ d[0];
    p2 = d[3] ^ d[1] ^ d[0];
    p3 = d[3] ^ d[2] ^ d[0];
    return {p1, p2, p3, d};
  endfunction

  // single-error correction; syndrome picks the bit to flip
  function automatic hm74_dec_t dec_word(input logic [6:0] cw);
    logic [2:0] syn;
    logic [6:0] flip;
    hm74_dec_t  r;
    syn = {cw[6] ^ cw[2] ^ cw[1] ^ cw[0],
           cw[5] ^ cw[3] ^ cw[1] ^ cw[0],
           cw[4] ^ cw[3] ^ cw[2] ^ cw[0]};
    case (syn)
      3'd1:    flip = 7'b001_0000;  // p3
      3'd2:    flip = 7'b010_0000;  // p2
      3'd3:    flip = 7'b000_1000;  // d3
      3'd4:    flip = 7'b100_0000;  // p1
      3'd5:    flip = 7'b000_0100;  // d2
      3'd6:    flip = 7'b000_0010;  // d1
      3'd7:    flip = 7'b000_0001;  // d0
      default: flip = 7'b000_0000;
    endcase
    r.nib   = 4'(cw ^ flip);
    r.fixed = (syn != 3'd0);
    return r;
  endfunction

endpackage

@@ hw/rtl/hamming_7_4_packed_codec_core.sv @@
// ----------------------------------------------------------------------------
// hamming_7_4_packed_codec_core
// Byte-stream Hamming(7,4) encoder/decoder with bit packing.
// ----------------------------------------------------------------------------
// Encode mode (cfg mode 0) turns every input byte into two 7-bit codewords,
// high nibble first, packed MSB first into output bytes; in_tlast flushes a
// partial byte with zero padding and marks the final output beat with tlast.
// Decode mode (mode 1) unpacks 7-bit groups, corrects one bit error per word,
// and repacks nibbles into bytes; leftover bits and an odd nibble are dropped
// at in_tlast. Throughput: an input beat enters the input register each
// cycle when the result register can take its batch; encode makes one to
// three output beats per input beat (in steady state 7 beats per 4 bytes,
// limited by the one-beat-per-cycle output port), decode makes at most one,
// so decode runs at 1 byte/cycle unless the output stalls. An accepted beat
// goes through the input register, then the result register. A cfg write
// sets mode and clears stream state; do it only while idle.
// ----------------------------------------------------------------------------
module hamming_7_4_packed_codec_core (
  input  logic       clk,
  input  logic       rst_n,
  // config
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,   // mode
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // [7:0] in_byte
  input  logic       in_tlast,      // in_last
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,     // [7:0] out_byte
  output logic       out_tlast,     // out_last
  output logic       out_tuser      // [0] corrected
);

  logic                  mode_r;
  hm74_pkg::hm74_state_t st_r, st_nxt;

  // input register
  logic       in_v_r;
  logic [7:0] in_data_r;
  logic       in_last_r;

  hm74_pkg::hm74_batch_t batch;
  hm74_pkg::hm74_res_t   head;
  logic                  q_free;
  logic                  advance;
  logic                  in_fire;
  logic                  out_fire;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  // a beat with no results never waits on the result register
  assign advance   = in_v_r && (q_free || (batch.n == 2'd0));
  assign in_tready = !in_v_r || advance;

  hm74_step u_step (
    .mode   (mode_r),
    .st     (st_r),
    .data   (in_data_r),
    .last   (in_last_r),
    .st_nxt (st_nxt),
    .batch  (batch)
  );

  hm74_out_q u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (advance && (batch.n != 2'd0)),
    .batch (batch),
    .pop   (out_fire),
    .head  (head),
    .valid (out_tvalid),
    .free  (q_free)
  );

  assign out_tdata = head.data;
  assign out_tlast = head.last;
  assign out_tuser = head.corr;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (!rst_n) begin
      in_v_r <= 1'b0;
      mode_r <= hm74_pkg::MODE_ENCODE;
      st_r   <= '0;
    end else begin
      if (in_fire) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
        st_r   <= '0;
      end else if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // encode keeps an even bit count below one byte
  a_enc_cnt : assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == hm74_pkg::MODE_ENCODE) |-> (!st_r.cnt[0] && (st_r.cnt < 5'd8)))
    else $error("encode pending bit count out of range");

  // decode never holds a full codeword between beats
  a_dec_cnt : assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == hm74_pkg::MODE_DECODE) |-> (st_r.cnt < 5'd7))
    else $error("decode pending bit count out of range");

  // corrected flag only appears in decode mode
  a_enc_corr : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (mode_r == hm74_pkg::MODE_ENCODE)) |-> !out_tuser)
    else $error("corrected flag set in encode mode");

  // after a beat with tlast the stream state is clean
  a_last_clr : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_last_r && !cfg_wr_en) |=> ((st_r.cnt == 5'd0) && !st_r.held))
    else $error("stream state not cleared after last beat");

endmodule

@@ hw/rtl/hm74_step.sv @@
// ----------------------------------------------------------------------------
// hm74_step
// Single-pass combinational step: stream state plus one byte gives the next
// state and up to three result beats.
// ----------------------------------------------------------------------------
module hm74_step (
  input  logic                 mode,
  input  hm74_pkg::hm74_state_t st,
  input  logic [7:0]           data,
  input  logic                 last,
  output hm74_pkg::hm74_state_t st_nxt,
  output hm74_pkg::hm74_batch_t batch
);

  // encode path
  logic [13:0]                  e_cw;
  logic [hm74_pkg::BufW-1:0]    e_bits;
  logic [hm74_pkg::CntW-1:0]    e_total;
  logic                         e_two;
  logic [hm74_pkg::CntW-1:0]    e_rem;
  logic [7:0]                   e_b0, e_b1, e_flush;
  logic                         e_do_flush;

  // decode path
  logic [hm74_pkg::BufW-1:0]    d_bits;
  logic [hm74_pkg::CntW-1:0]    d_total;
  logic                         d_two;
  logic [hm74_pkg::CntW-1:0]    d_rem;
  logic [6:0]                   d_w0;
  hm74_pkg::hm74_dec_t          d_r0, d_r1;

  assign e_cw    = {hm74_pkg::enc_nibble(data[7:4]), hm74_pkg::enc_nibble(data[3:0])};
  assign e_bits  = {st.bits[hm74_pkg::BufW-15:0], e_cw};
  assign e_total = st.cnt + hm74_pkg::CntW'(14);
  assign e_two   = (e_total >= hm74_pkg::CntW'(16));
  assign e_rem   = e_two ? e_total - hm74_pkg::CntW'(16) : e_total - hm74_pkg::CntW'(8);
  assign e_b0    = 8'(e_bits >> (e_total - hm74_pkg::CntW'(8)));
  assign e_b1    = 8'(e_bits >> (e_total - hm74_pkg::CntW'(16)));
  assign e_flush = 8'(e_bits << (hm74_pkg::CntW'(8) - e_rem));
  assign e_do_flush = last && (e_rem != '0);

  assign d_bits  = {st.bits[hm74_pkg::BufW-9:0], data};
  assign d_total = st.cnt + hm74_pkg::CntW'(8);
  assign d_two   = (d_total >= hm74_pkg::CntW'(14));
  assign d_rem   = d_two ? d_total - hm74_pkg::CntW'(14) : d_total - hm74_pkg::CntW'(7);
  assign d_w0    = 7'(d_bits >> (d_total - hm74_pkg::CntW'(7)));
  assign d_r0    = hm74_pkg::dec_word(d_w0);
  assign d_r1    = hm74_pkg::dec_word(d_bits[6:0]);

  always_comb begin
    st_nxt = st;
    batch  = '0;
    if (mode == hm74_pkg::MODE_ENCODE) begin
      st_nxt.bits = e_bits & ((hm74_pkg::BufW'(1) << e_rem) - hm74_pkg::BufW'(1));
      st_nxt.cnt  = e_rem;
      batch.ent[0].data = e_b0;
      if (e_two) begin
        batch.ent[1].data = e_b1;
        batch.ent[2].data = e_flush;
        batch.n = e_do_flush ? 2'd3 : 2'd2;
      end else begin
        batch.ent[1].data = e_flush;
        batch.n = e_do_flush ? 2'd2 : 2'd1;
      end
    end else begin
      st_nxt.bits = d_bits & ((hm74_pkg::BufW'(1) << d_rem) - hm74_pkg::BufW'(1));
      st_nxt.cnt  = d_rem;
      if (st.held) begin
        // pair completes with the first word; a second word is held
        batch.n = 2'd1;
        batch.ent[0].data = {st.held_nib, d_r0.nib};
        batch.ent[0].corr = st.err | d_r0.fixed;
        st_nxt.held     = d_two;
        st_nxt.held_nib = d_two ? d_r1.nib : 4'd0;
        st_nxt.err      = d_two & d_r1.fixed;
      end else if (d_two) begin
        batch.n = 2'd1;
        batch.ent[0].data = {d_r0.nib, d_r1.nib};
        batch.ent[0].corr = d_r0.fixed | d_r1.fixed;
        st_nxt.held     = 1'b0;
        st_nxt.held_nib = 4'd0;
        st_nxt.err      = 1'b0;
      end else begin
        st_nxt.held     = 1'b1;
        st_nxt.held_nib = d_r0.nib;
        st_nxt.err      = d_r0.fixed;
      end
    end
    if (last) begin
      case (batch.n)
        2'd1:    batch.ent[0].last = 1'b1;
        2'd2:    batch.ent[1].last = 1'b1;
        2'd3:    batch.ent[2].last = 1'b1;
        default: ;
      endcase
      st_nxt = '0;
    end
  end

endmodule

@@ hw/rtl/hm74_out_q.sv @@
// ----------------------------------------------------------------------------
// hm74_out_q
// Result register: holds the beats of one step and drains one per cycle while the receiver takes them.
// ----------------------------------------------------------------------------
module hm74_out_q (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  hm74_pkg::hm74_batch_t batch,
  input  logic                  pop,
  output hm74_pkg::hm74_res_t   head,
  output logic                  valid,
  output logic                  free
);

  hm74_pkg::hm74_res_t [hm74_pkg::MaxRes-1:0] ent_r, ent_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign head  = ent_r[0];
  assign valid = (cnt_r != 2'd0);
  // free next cycle: empty, or last beat leaving now
  assign free  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);

  always_comb begin
    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    if (load) begin
      ent_nxt = batch.ent;
      cnt_nxt = batch.n;
    end else if (pop) begin
      ent_nxt = {ent_r[2], ent_r[2], ent_r[1]};
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the packed Hamming(7,4) byte codec.
// ----------------------------------------------------------------------------
// A queue of bytes feeds an input driver. A bit-accurate predictor runs on
// every accepted input beat and queues the output beats it implies. A monitor
// checks each output beat against the oldest queued one. Both sides insert
// random gaps. One phase holds the output off for a long stretch so that the
// core backs up and drops in_tready. Directed encode and decode streams come
// first, then random phases that alternate the mode.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SETTLE_CYC = 8;     // idle cycles after the last result
  localparam int LONG_HOLD  = 300;   // receiver hold-off for back-pressure
  localparam int STALL_MAX  = 2000;  // watchdog: cycles with no handshake

  // check-matrix rows over {p1 p2 p3 d3 d2 d1 d0}
  localparam logic [6:0] ROW_P1 = 7'b100_0111;
  localparam logic [6:0] ROW_P2 = 7'b010_1011;
  localparam logic [6:0] ROW_P3 = 7'b001_1101;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } stim_beat_t;

  logic       clk;
  logic       rst_n       = 1'b0;
  logic       cfg_wr_en   = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_tvalid   = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata    = '0;
  logic       in_tlast    = 1'b0;
  logic       out_tvalid;
  logic       out_tready  = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  hamming_7_4_packed_codec_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state: mirrors the core's stream state and mode register.
  // --------------------------------------------------------------------------
  logic        codec_mode;
  logic [20:0] pend_bits;    // bits not yet packed/unpacked, right-aligned
  logic [4:0]  pend_cnt;
  logic [3:0]  half_nib;     // decoded first nibble waiting for its partner
  logic        half_valid;
  logic        half_err;

  stim_beat_t            tx_bytes[$];         // bytes waiting for the input driver
  hm74_pkg::hm74_res_t   pending_results[$];  // output beats still owed by the core
  int                    queued;              // bytes pushed so far
  int                    errors;

  // sender / receiver pacing, set by the sequencer
  bit          in_steady;
  bit          out_steady;
  int          in_gap_left;
  int          out_stall_left;
  int          long_holds_req;
  int          long_holds_done;

  function automatic logic [6:0] hamming_encode(input logic [3:0] d);
    return {^(d & 4'b0111), ^(d & 4'b1011), ^(d & 4'b1101), d};
  endfunction

  // syndrome equals the check-matrix column of the bad bit
  function automatic void hamming_correct(input logic [6:0] cw, output logic [3:0] nib,
                                          output logic fixed);
    logic [2:0] syn;
    logic [6:0] word;
    word = cw;
    syn  = {^(cw & ROW_P1), ^(cw & ROW_P2), ^(cw & ROW_P3)};
    for (int i = 0; i < 7; i++) begin
      if (syn != 3'd0 && {ROW_P1[i], ROW_P2[i], ROW_P3[i]} == syn) word[i] = ~word[i];
    end
    nib   = word[3:0];
    fixed = (syn != 3'd0);
  endfunction

  function automatic void clear_stream();
    pend_bits  = '0;
    pend_cnt   = '0;
    half_nib   = '0;
    half_valid = 1'b0;
    half_err   = 1'b0;
  endfunction

  // work out the output beats caused by one accepted input beat
  function automatic void predict_codec_beat(input logic [7:0] b, input logic lst);
    hm74_pkg::hm74_res_t beats[$];
    hm74_pkg::hm74_res_t r;
    int                  t;
    logic [3:0]          nib;
    logic                fixed;
    if (codec_mode == hm74_pkg::MODE_ENCODE) begin
      pend_bits = {pend_bits[6:0], hamming_encode(b[7:4]), hamming_encode(b[3:0])};
      pend_cnt  = pend_cnt + 5'd14;
      while (pend_cnt >= 5'd8 && beats.size() < hm74_pkg::MaxRes) begin
        pend_cnt = pend_cnt - 5'd8;
        t = int'(pend_bits) >> pend_cnt;
        r = '{data: t[7:0], last: 1'b0, corr: 1'b0};
        beats.push_back(r);
        pend_bits = pend_bits & ((21'd1 << pend_cnt) - 21'd1);
      end
      // flush: leftover bits go out MSB-aligned, zero padded
      if (lst && pend_cnt != 5'd0 && pend_cnt < 5'd8 && beats.size() < hm74_pkg::MaxRes) begin
        t = int'(pend_bits) << (8 - int'(pend_cnt));
        r = '{data: t[7:0], last: 1'b0, corr: 1'b0};
        beats.push_back(r);
      end
    end else begin
      pend_bits = {pend_bits[12:0], b};
      pend_cnt  = pend_cnt + 5'd8;
      while (pend_cnt >= 5'd7) begin
        pend_cnt = pend_cnt - 5'd7;
        t = int'(pend_bits) >> pend_cnt;
        hamming_correct(t[6:0], nib, fixed);
        pend_bits = pend_bits & ((21'd1 << pend_cnt) - 21'd1);
        if (half_valid) begin
          if (beats.size() < hm74_pkg::MaxRes) begin
            r = '{data: {half_nib, nib}, last: 1'b0, corr: half_err | fixed};
            beats.push_back(r);
          end
          half_valid = 1'b0;
          half_nib   = '0;
          half_err   = 1'b0;
        end else begin
          half_nib   = nib;
          half_valid = 1'b1;
          half_err   = fixed;
        end
      end
    end
    if (lst) begin
      // a decode end that emits nothing leaves the stream unmarked
      if (beats.size() != 0) beats[beats.size()-1].last = 1'b1;
      clear_stream();
    end
    foreach (beats[i]) pending_results.push_back(beats[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: one beat in flight, random gap before each new byte.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_in
    stim_beat_t nb;
    if (!rst_n) begin
      in_tvalid   <= 1'b0;
      in_tdata    <= '0;
      in_tlast    <= 1'b0;
      in_gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_codec_beat(in_tdata, in_tlast);
        in_gap_left = in_steady ? 0 : $urandom_range(0, 9);
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap_left > 0) begin
          in_gap_left--;
          in_tvalid <= 1'b0;
        end else if (tx_bytes.size() != 0) begin
          nb = tx_bytes.pop_front();
          in_tdata  <= nb.data;
          in_tlast  <= nb.last;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: checks every beat, stalls at random, and serves requests
  // for a long hold-off.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_out
    hm74_pkg::hm74_res_t exp_beat;
    if (!rst_n) begin
      out_tready     <= 1'b0;
      out_stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat data=%02h last=%0b corr=%0b", $time,
                   out_tdata, out_tlast, out_tuser);
        end else begin
          exp_beat = pending_results.pop_front();
          if (out_tdata !== exp_beat.data) begin
            errors++;
            $display("%0t: data mismatch: expected %02h actual %02h", $time,
                     exp_beat.data, out_tdata);
          end
          if (out_tlast !== exp_beat.last) begin
            errors++;
            $display("%0t: tlast mismatch: expected %0b actual %0b", $time,
                     exp_beat.last, out_tlast);
          end
          if (out_tuser !== exp_beat.corr) begin
            errors++;
            $display("%0t: corrected mismatch: expected %0b actual %0b", $time,
                     exp_beat.corr, out_tuser);
          end
        end
        out_stall_left = out_steady ? 0 : $urandom_range(0, 9);
      end
      if (long_holds_done != long_holds_req) begin
        long_holds_done++;
        out_stall_left = LONG_HOLD;
      end
      if (out_stall_left > 0) begin
        out_stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any handshake ends the run.
  // --------------------------------------------------------------------------
  int quiet_cycles;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("%0t: timeout, %0d beats still expected", $time, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic lst);
    stim_beat_t sb;
    sb.data = b;
    sb.last = lst;
    tx_bytes.push_back(sb);
    queued++;
  endtask

  // Well-formed coded stream: nnib random nibbles, each codeword gets
  // 'flips' bit errors (negative: mostly clean, some single, few double).
  task automatic send_coded(input int nnib, input int flips, input bit close);
    logic [7:0] bytes[$];
    logic [6:0] cw;
    int         acc;
    int         nacc;
    int         nf;
    int         p;
    int         q;
    int         roll;
    acc  = 0;
    nacc = 0;
    for (int k = 0; k < nnib; k++) begin
      cw = hamming_encode(4'($urandom));
      if (flips >= 0) begin
        nf = flips;
      end else begin
        roll = $urandom_range(0, 99);
        nf   = (roll < 70) ? 0 : (roll < 92) ? 1 : 2;
      end
      p = $urandom_range(0, 6);
      q = (p + 1 + $urandom_range(0, 5)) % 7;
      if (nf >= 1) cw[p] = ~cw[p];
      if (nf >= 2) cw[q] = ~cw[q];
      acc  = (acc << 7) | int'(cw);
      nacc += 7;
      while (nacc >= 8) begin
        nacc -= 8;
        bytes.push_back(8'(acc >> nacc));
        acc &= (1 << nacc) - 1;
      end
    end
    // tail padded with random bits; the core drops short groups
    if (nacc > 0) bytes.push_back(8'((acc << (8 - nacc)) | ($urandom & ((1 << (8 - nacc)) - 1))));
    foreach (bytes[i]) send_byte(bytes[i], close && (i == bytes.size() - 1));
  endtask

  // idle means nothing queued, offered, owed or on the output for a while;
  // a decode beat may make no result but still be in the pipe
  task automatic wait_idle();
    int calm;
    calm = 0;
    while (calm < SETTLE_CYC) begin
      @(posedge clk);
      if (tx_bytes.size() != 0 || in_tvalid || out_tvalid || pending_results.size() != 0)
        calm = 0;
      else
        calm++;
    end
  endtask

  task automatic write_mode(input logic m);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    codec_mode = m;
    clear_stream();
  endtask

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin
    int start;
    int len;
    bit enc;
    codec_mode = hm74_pkg::MODE_ENCODE;
    clear_stream();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed encode: flushes of 6 and 4 bits, exact fit, open stream
    write_mode(hm74_pkg::MODE_ENCODE);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);   // three beats from one input beat
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b1);   // 56 bits: nothing left to flush
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b0);   // left open, cleared by the mode write
    wait_idle();

    // directed decode: clean, single errors, double errors, dropped tails
    write_mode(hm74_pkg::MODE_DECODE);
    send_coded(4, 0, 1'b1);
    send_coded(4, 1, 1'b1);
    send_coded(2, 2, 1'b1);
    send_byte(8'hFF, 1'b1);   // one codeword, odd nibble dropped, no output
    send_coded(3, 0, 1'b1);   // final beat emits nothing, stream unmarked
    wait_idle();

    // random phases, alternating mode
    for (int ph = 0; ph < 6; ph++) begin
      enc = (ph % 2 == 0);
      write_mode(enc ? hm74_pkg::MODE_ENCODE : hm74_pkg::MODE_DECODE);
      in_steady  = (ph == 2 || ph == 3);
      out_steady = (ph == 3);
      start = queued;
      if (ph == 2) begin
        // output held off while the sender keeps pushing a long stream
        long_holds_req++;
        for (int k = 0; k < 40; k++) send_byte(8'($urandom), k == 39);
      end
      while (queued - start < 25) begin
        if (enc) begin
          len = $urandom_range(1, 8);
          for (int k = 0; k < len; k++)
            send_byte(8'($urandom), (k == len - 1) && ($urandom_range(0, 9) != 0));
        end else if ($urandom_range(0, 4) != 0) begin
          send_coded($urandom_range(1, 12), -1, $urandom_range(0, 9) != 0);
        end else begin
          len = $urandom_range(1, 5);
          for (int k = 0; k < len; k++)
            send_byte(8'($urandom), (k == len - 1) && $urandom_range(0, 1));
        end
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
